// ----- src/siir12_pkg.sv -----
// Package for the stereo 12th-order IIR lowpass: word types, widths, coefficients.
`default_nettype none

package siir12_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int HIST_BITS   = SAMPLE_BITS + 8;
    localparam int COEF_BITS   = 32;
    localparam int ACC_BITS    = SAMPLE_BITS + 42;
    localparam int TAPS_FF     = 13;
    localparam int TAPS_FB     = 12;
    localparam int CHANNELS    = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } frame_out_t;

    // Feedforward taps, Q3.28, index 0 pairs with the oldest input.
    localparam logic signed [COEF_BITS-1:0] COEF_B [TAPS_FF] = '{
        32'sd671214,   32'sd3336313,  32'sd9959834,  32'sd21243399, 32'sd35253086,
        32'sd47199853, 32'sd51931125, 32'sd47199853, 32'sd35253086, 32'sd21243399,
        32'sd9959834,  32'sd3336313,  32'sd671214
    };

    // Feedback taps already negated, Q3.28, index 0 pairs with the oldest output.
    localparam logic signed [COEF_BITS-1:0] NEG_A [TAPS_FB] = '{
        -32'sd6047,      32'sd76310,     -32'sd1126181,   32'sd5991715,
        -32'sd31505306,  32'sd95976436,  -32'sd270100346, 32'sd502782708,
        -32'sd846169892, 32'sd943338963, -32'sd944038033, 32'sd525956602
    };

endpackage

`default_nettype wire

// ----- src/stereo_iir_lowpass_order12.sv -----
// Stereo 12th-order direct-form-I IIR lowpass, one frame per cycle while result_stall is low.
//
// Usage:
//   Input channel (frame_valid / frame_stall / frame) carries one stereo word:
//   a signed 24-bit left and right sample. Output channel (result_valid /
//   result_stall / result) carries one filtered stereo word per input word.
//   A word moves at a rising edge where valid is high and stall is low.
// Path: an accepted word lands in the input register; an advance then runs
//   both channels through the full 25-tap sum of products and loads the result
//   register, which raises result_valid.
// Throughput: one word per cycle while result_stall is low, set by the feedback
//   path: the newest stored output feeds the next sum, so all 25 products per
//   channel and the rounding/saturation sit between the input register and the
//   result register, with the history registers updated on the same edge.
// Stall: while the result register waits on result_stall, the input register
//   still takes one more word; frame_stall rises only when both hold a word
//   and result_stall is high.
// Reset (rst_n low, asynchronous): both valid flags drop and all input and
//   output history clears to zero, matching a filter at rest.
`default_nettype none

module stereo_iir_lowpass_order12
    import siir12_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       frame_valid,
    output logic            frame_stall,
    input  wire frame_in_t  frame,
    output logic            result_valid,
    input  wire logic       result_stall,
    output frame_out_t      result
);

    localparam int FF_PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int FB_PROD_BITS = HIST_BITS + COEF_BITS;
    localparam int Q_BITS       = ACC_BITS - 28;
    localparam int OQ_BITS      = HIST_BITS - 7;

    localparam logic signed [ACC_BITS-1:0]  ROUND_ACC = ACC_BITS'(1) <<< 27;
    localparam logic signed [HIST_BITS-1:0] HIST_MAX  = {1'b0, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [HIST_BITS-1:0] HIST_MIN  = {1'b1, {(HIST_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Input register stage.
    logic       in_valid_reg;
    frame_in_t  in_reg;

    // Result register stage.
    logic       result_valid_reg;
    frame_out_t result_reg;
    frame_out_t result_next;

    // History, index 0 oldest, index TAPS_FB-1 newest.
    logic signed [SAMPLE_BITS-1:0] xh_reg [CHANNELS][TAPS_FB];
    logic signed [HIST_BITS-1:0]   yh_reg [CHANNELS][TAPS_FB];

    logic signed [SAMPLE_BITS-1:0] x_cur  [CHANNELS];
    logic signed [HIST_BITS-1:0]   h_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] o_next [CHANNELS];

    logic advance;
    logic take_in;

    // Move the held word into the result register when that slot frees up.
    assign advance     = in_valid_reg && (!result_valid_reg || !result_stall);
    assign frame_stall = in_valid_reg && !advance;
    assign take_in     = frame_valid && !frame_stall;

    assign x_cur[0] = in_reg.left_in;
    assign x_cur[1] = in_reg.right_in;

    // Sum of products, round, saturate: one pass per channel.
    always_comb
    begin
        logic signed [ACC_BITS-1:0]     acc;
        logic signed [FF_PROD_BITS-1:0] pb;
        logic signed [FB_PROD_BITS-1:0] pa;
        logic signed [ACC_BITS-1:0]     rnd;
        logic signed [Q_BITS-1:0]       q;
        logic signed [HIST_BITS:0]      o_sum;
        logic signed [OQ_BITS-1:0]      o_q;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            acc = '0;
            for (int k = 0; k < TAPS_FB; k++)
            begin
                pb  = xh_reg[ch][k] * COEF_B[k];
                acc = acc + (ACC_BITS'(pb) <<< 8);
            end
            pb  = x_cur[ch] * COEF_B[TAPS_FF-1];
            acc = acc + (ACC_BITS'(pb) <<< 8);
            for (int k = 0; k < TAPS_FB; k++)
            begin
                pa  = yh_reg[ch][k] * NEG_A[k];
                acc = acc + ACC_BITS'(pa);
            end

            // Round half up, drop 28 fraction bits, clamp to history width.
            rnd = acc + ROUND_ACC;
            q   = rnd[ACC_BITS-1:28];
            if (q > Q_BITS'(HIST_MAX))
                h_next[ch] = HIST_MAX;
            else if (q < Q_BITS'(HIST_MIN))
                h_next[ch] = HIST_MIN;
            else
                h_next[ch] = q[HIST_BITS-1:0];

            // Drop the 8 guard bits with rounding, clamp to sample width.
            o_sum = (HIST_BITS+1)'(h_next[ch]) + (HIST_BITS+1)'(128);
            o_q   = o_sum[HIST_BITS:8];
            if (o_q > OQ_BITS'(OUT_MAX))
                o_next[ch] = OUT_MAX;
            else if (o_q < OQ_BITS'(OUT_MIN))
                o_next[ch] = OUT_MIN;
            else
                o_next[ch] = o_q[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        result_next.left_out  = o_next[0];
        result_next.right_out = o_next[1];
    end

    // Control and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int k = 0; k < TAPS_FB; k++)
                begin
                    xh_reg[ch][k] <= '0;
                    yh_reg[ch][k] <= '0;
                end
            end
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            // Shift history by one frame on each advance.
            if (advance)
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    for (int k = 0; k < TAPS_FB - 1; k++)
                    begin
                        xh_reg[ch][k] <= xh_reg[ch][k+1];
                        yh_reg[ch][k] <= yh_reg[ch][k+1];
                    end
                    xh_reg[ch][TAPS_FB-1] <= x_cur[ch];
                    yh_reg[ch][TAPS_FB-1] <= h_next[ch];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_reg <= frame;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // Input stalls only when both stages hold a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (in_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled while a stage was free");

    // An advance always presents a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("advanced word did not reach the result register");

    // The newest input history entry is the word that just advanced.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (xh_reg[0][TAPS_FB-1] == $past(in_reg.left_in))
                 && (xh_reg[1][TAPS_FB-1] == $past(in_reg.right_in)))
        else $error("input history did not capture the advanced word");

    // History holds while no word advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(yh_reg[0][TAPS_FB-1]) && $stable(yh_reg[1][TAPS_FB-1]))
        else $error("output history moved without an advance");
`endif

endmodule

`default_nettype wire
